/* design/packet_queue_admission_dropper_macros.svh */
// Assertion macros for the packet queue admission block.
// Used by design/packet_queue_admission_dropper.sv; no other dependencies.
`ifndef PACKET_QUEUE_ADMISSION_DROPPER_MACROS_SVH
`define PACKET_QUEUE_ADMISSION_DROPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PQAD_ASSERT_HOLDS(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define PQAD_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

/* design/pqad_pkg.sv */
// Shared types and constants for the packet queue admission block.
// No dependencies.
`timescale 1ns / 1ps

package pqad_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int SIZE_W   = 20;   // packet_size / ring entry width
	localparam int BYTE_W   = 32;   // byte totals, budget, drop counter
	localparam int OUTCNT_W = 9;    // evicted_count, queued_packets
	localparam int CFG_W    = 32;   // widest configuration register
	localparam int CFG_IDX_W = 2;

	localparam logic [OUTCNT_W-1:0] EV_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PORT  = 2'd2;

	localparam logic [BYTE_W-1:0] MEM_LIMIT_RST = 32'd1048576;

	// drop modes; the unused code behaves as tail drop
	localparam logic [1:0] DM_REFUSE = 2'd0;
	localparam logic [1:0] DM_HEAD   = 2'd1;
	localparam logic [1:0] DM_TAIL   = 2'd2;

	localparam logic [1:0] DIR_TO_HOST  = 2'd0;
	localparam logic [1:0] DIR_OUTGOING = 2'd1;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	typedef enum logic [2:0] {
		V_QUEUED   = 3'd0,
		V_OWN      = 3'd1,
		V_FILTERED = 3'd2,
		V_NOSPACE  = 3'd3,
		V_PURGE    = 3'd4,
		V_TAKEN    = 3'd5,
		V_EMPTY    = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_VICT
	} state_t;

endpackage

/* design/packet_queue_admission_dropper.sv */
// Packet queue admission with a byte budget and head or tail eviction.
// Depends on pqad_pkg and packet_queue_admission_dropper_macros.svh.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_axis_*: one item per packet arrival (tuser = 0) or per
//   consumer take of the head entry (tuser = 1). Output channel m_axis_*: one
//   result item per input item, in order, carrying the verdict in tuser and
//   the evicted count, taken size and post-step queue totals in tdata.
//   Configuration: cfg_wr_en / cfg_index / cfg_wdata write mem_limit (0),
//   drop_mode (1) and own_port (2); write only while the block is idle.
// Timing:
//   An item is accepted in the idle state, which also fetches the head entry
//   from the size ring. The next cycle decides the item. Each eviction reads
//   the victim from the single-port ring into a read register and checks it
//   against the byte total in the following cycle, then decides again.
// Reset:
//   arst_n clears the queue indices, counts and drop counter and loads the
//   register defaults. Ring contents are not cleared; only written entries
//   are ever used, so no clearing pass is needed.
// Backpressure:
//   A finished result sits in the output register; a new item is accepted
//   while it waits. If the next result is ready while the receiver still
//   stalls, hold the decision state until the output register frees up.

`include "packet_queue_admission_dropper_macros.svh"

module packet_queue_admission_dropper #(
	parameter int QUEUE_DEPTH = pqad_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [pqad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pqad_pkg::CFG_W-1:0]         cfg_wdata,
	// input items
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata, low bit up: is_ipv4[0], pkt_dir[2:1], ip_protocol[10:3],
	// src_port[26:11], dst_port[42:27], filter_pass[43], packet_size[63:44],
	// sent_bytes[95:64]
	input  logic [95:0]                        s_axis_tdata,
	// tuser: op[0]
	input  logic                               s_axis_tuser,
	// result items
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata, low bit up: evicted_count[8:0], taken_size[28:9],
	// queued_bytes[60:29], queued_packets[69:61], drop_count[101:70], zero pad
	output logic [103:0]                       m_axis_tdata,
	// tuser: verdict[2:0]
	output logic [2:0]                         m_axis_tuser
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam int SW = pqad_pkg::SIZE_W;
	localparam int BW = pqad_pkg::BYTE_W;
	localparam int OW = pqad_pkg::OUTCNT_W;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	// configuration registers
	logic [BW-1:0] mem_limit_q;
	logic [1:0]    drop_mode_q;
	logic [15:0]   own_port_q;

	// latched input item
	logic          op_q;
	logic          is_ipv4_q;
	logic [1:0]    pkt_dir_q;
	logic [7:0]    ip_protocol_q;
	logic [15:0]   src_port_q;
	logic [15:0]   dst_port_q;
	logic          filter_pass_q;
	logic [SW-1:0] packet_size_q;
	logic [BW-1:0] sent_bytes_q;

	// queue state
	pqad_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [BW-1:0]    bt_q, bt_d;
	logic [BW-1:0]    drop_q, drop_d;
	logic [OW-1:0]    ev_q, ev_d;

	// size ring
	logic [SW-1:0]    size_ring_q [QUEUE_DEPTH];
	logic [SW-1:0]    rd_data_s1;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             ring_we;

	// output register
	logic                 out_valid_q;
	pqad_pkg::verdict_t   out_verdict_q;
	logic [OW-1:0]        out_ev_q;
	logic [SW-1:0]        out_taken_q;
	logic [BW-1:0]        out_bt_q;
	logic [OW-1:0]        out_cnt_q;
	logic [BW-1:0]        out_drop_q;

	// decisions
	logic               in_acc;
	logic               out_free;
	logic               own_traffic;
	logic               over_budget;
	logic               want_fin;
	logic               fin_go;
	logic               evict_go;
	logic               vict_bad;
	logic               empty_settled;
	pqad_pkg::verdict_t verdict;
	logic [SW-1:0]      taken;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// classify own TCP/UDP traffic on the configured port
	assign own_traffic = is_ipv4_q
		&& ((ip_protocol_q == pqad_pkg::PROTO_TCP) || (ip_protocol_q == pqad_pkg::PROTO_UDP))
		&& (((pkt_dir_q == pqad_pkg::DIR_TO_HOST) && (dst_port_q == own_port_q))
		|| ((pkt_dir_q == pqad_pkg::DIR_OUTGOING) && (src_port_q == own_port_q)));

	// budget compare without wrap: queued + sent + new >= limit
	assign over_budget = ({2'b00, bt_q} + {2'b00, sent_bytes_q}
		+ {{(BW + 2 - SW){1'b0}}, packet_size_q}) >= {2'b00, mem_limit_q};

	assign vict_bad = (bt_q < {{(BW - SW){1'b0}}, rd_data_s1});

	// the byte total trails the count while a victim is checked
	assign empty_settled = (cnt_q == '0) && (state_q != pqad_pkg::S_VICT);

	// decide whether this cycle finishes the item or starts an eviction
	always_comb begin
		want_fin = 1'b0;
		evict_go = 1'b0;
		verdict  = pqad_pkg::V_QUEUED;
		case (state_q)
			pqad_pkg::S_EVAL: begin
				want_fin = 1'b1;
				if (op_q == pqad_pkg::OP_TAKE) begin
					verdict = (cnt_q == '0) ? pqad_pkg::V_EMPTY : pqad_pkg::V_TAKEN;
				end else if (own_traffic) begin
					verdict = pqad_pkg::V_OWN;
				end else if (!filter_pass_q) begin
					verdict = pqad_pkg::V_FILTERED;
				end else if (!over_budget) begin
					verdict = (cnt_q >= FULL_CNT) ? pqad_pkg::V_NOSPACE : pqad_pkg::V_QUEUED;
				end else if ((bt_q < {{(BW - SW){1'b0}}, packet_size_q})
						|| (drop_mode_q == pqad_pkg::DM_REFUSE)) begin
					verdict = pqad_pkg::V_NOSPACE;
				end else if (cnt_q == '0) begin
					verdict = pqad_pkg::V_PURGE;
				end else begin
					want_fin = 1'b0;
					evict_go = 1'b1;
				end
			end
			pqad_pkg::S_VICT: begin
				want_fin = vict_bad;
				verdict  = pqad_pkg::V_PURGE;
			end
			default: begin
				want_fin = 1'b0;
			end
		endcase
	end

	assign fin_go = want_fin && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pqad_pkg::S_IDLE: begin
				if (in_acc) state_d = pqad_pkg::S_EVAL;
			end
			pqad_pkg::S_EVAL: begin
				if (evict_go) state_d = pqad_pkg::S_VICT;
				else if (fin_go) state_d = pqad_pkg::S_IDLE;
			end
			pqad_pkg::S_VICT: begin
				if (!vict_bad) state_d = pqad_pkg::S_EVAL;
				else if (fin_go) state_d = pqad_pkg::S_IDLE;
			end
			default: state_d = pqad_pkg::S_IDLE;
		endcase
	end

	// state updates, ring access and result values
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		bt_d    = bt_q;
		drop_d  = drop_q;
		ev_d    = ev_q;
		taken   = '0;
		ring_we = 1'b0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			pqad_pkg::S_IDLE: begin
				// prefetch the head entry for a take
				rd_en = 1'b1;
				if (in_acc) ev_d = '0;
			end
			pqad_pkg::S_EVAL: begin
				if (evict_go) begin
					drop_d = drop_q + 1'b1;
					cnt_d  = cnt_q - 1'b1;
					rd_en  = 1'b1;
					if (drop_mode_q == pqad_pkg::DM_HEAD) begin
						rd_addr = head_q;
						head_d  = idx_inc(head_q);
					end else begin
						rd_addr = idx_dec(tail_q);
						tail_d  = idx_dec(tail_q);
					end
				end else if (fin_go) begin
					case (verdict)
						pqad_pkg::V_TAKEN: begin
							taken  = rd_data_s1;
							head_d = idx_inc(head_q);
							cnt_d  = cnt_q - 1'b1;
							bt_d   = vict_bad ? '0 : bt_q - {{(BW - SW){1'b0}}, rd_data_s1};
						end
						pqad_pkg::V_QUEUED: begin
							ring_we = 1'b1;
							tail_d  = idx_inc(tail_q);
							cnt_d   = cnt_q + 1'b1;
							bt_d    = bt_q + {{(BW - SW){1'b0}}, packet_size_q};
						end
						pqad_pkg::V_NOSPACE: begin
							// refusal after the loop is no drop round
							if (over_budget) drop_d = drop_q + 1'b1;
						end
						pqad_pkg::V_PURGE: begin
							drop_d = drop_q + 1'b1;
							head_d = '0;
							tail_d = '0;
							cnt_d  = '0;
							bt_d   = '0;
						end
						default: begin
							head_d = head_q;
						end
					endcase
				end
			end
			pqad_pkg::S_VICT: begin
				if (!vict_bad) begin
					bt_d = bt_q - {{(BW - SW){1'b0}}, rd_data_s1};
					if (ev_q != pqad_pkg::EV_MAX) ev_d = ev_q + 1'b1;
				end else if (fin_go) begin
					head_d = '0;
					tail_d = '0;
					cnt_d  = '0;
					bt_d   = '0;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == pqad_pkg::S_IDLE);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_limit_q <= pqad_pkg::MEM_LIMIT_RST;
			drop_mode_q <= pqad_pkg::DM_REFUSE;
			own_port_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pqad_pkg::REG_MEM_LIMIT: mem_limit_q <= cfg_wdata;
				pqad_pkg::REG_DROP_MODE: drop_mode_q <= cfg_wdata[1:0];
				pqad_pkg::REG_OWN_PORT:  own_port_q  <= cfg_wdata[15:0];
				default: mem_limit_q <= mem_limit_q;
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q          <= s_axis_tuser;
			is_ipv4_q     <= s_axis_tdata[0];
			pkt_dir_q     <= s_axis_tdata[2:1];
			ip_protocol_q <= s_axis_tdata[10:3];
			src_port_q    <= s_axis_tdata[26:11];
			dst_port_q    <= s_axis_tdata[42:27];
			filter_pass_q <= s_axis_tdata[43];
			packet_size_q <= s_axis_tdata[63:44];
			sent_bytes_q  <= s_axis_tdata[95:64];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqad_pkg::S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			bt_q    <= '0;
			drop_q  <= '0;
			ev_q    <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			bt_q    <= bt_d;
			drop_q  <= drop_d;
			ev_q    <= ev_d;
		end
	end

	// size ring: a read and a write are never enabled together, so the same
	// entry is never read and written in one cycle
	always_ff @(posedge clk) begin
		if (ring_we) size_ring_q[tail_q] <= packet_size_q;
		if (rd_en) rd_data_s1 <= size_ring_q[rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_verdict_q <= verdict;
			out_ev_q      <= ev_q;
			out_taken_q   <= taken;
			out_bt_q      <= bt_d;
			out_cnt_q     <= OW'(cnt_d);
			out_drop_q    <= drop_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_verdict_q;
	assign m_axis_tdata  = {2'b00, out_drop_q, out_cnt_q, out_bt_q, out_taken_q, out_ev_q};

	`PQAD_ASSERT_HOLDS(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= FULL_CNT, "entry count above depth")
	`PQAD_ASSERT_HOLDS(a_empty_ptrs, clk, arst_n, empty_settled, (head_q == tail_q) && (bt_q == '0), "empty queue with stale pointers or bytes")
	`PQAD_ASSERT_HOLDS(a_ring_port, clk, arst_n, 1'b1, !(ring_we && rd_en), "ring read and write in one cycle")
	`PQAD_ASSERT_NEXT(a_accept_eval, clk, arst_n, in_acc, state_q == pqad_pkg::S_EVAL, "accepted item not evaluated")

endmodule

/* sim/tb_packet_queue_admission_dropper.sv */
// Self-checking testbench for packet_queue_admission_dropper: a directed stimulus table, then
// random phases under several register settings, each result item checked in order.
// Depends on pqad_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_packet_queue_admission_dropper;

	localparam int DEPTH       = pqad_pkg::QUEUE_DEPTH_DEF;
	localparam int HOLD_AT     = 400;   // result count at which the receiver holds off
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;    // settle time after the last result item
	localparam int REPORT_MAX  = 10;

	// codes the package leaves unnamed
	localparam logic [1:0] DM_UNUSED    = 2'd3;   // behaves as tail drop
	localparam logic [1:0] DIR_OTHER    = 2'd2;
	localparam logic [1:0] DIR_RESERVED = 2'd3;

	// input item payload, last field in the lowest bits
	typedef struct packed {
		logic [31:0] sent_bytes;
		logic [19:0] packet_size;
		logic        filter_pass;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [7:0]  ip_protocol;
		logic [1:0]  pkt_dir;
		logic        is_ipv4;
	} pkt_fields_t;

	// result item payload, last field in the lowest bits
	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] drop_count;
		logic [8:0]  queued_packets;
		logic [31:0] queued_bytes;
		logic [19:0] taken_size;
		logic [8:0]  evicted_count;
	} res_fields_t;

	typedef struct packed {
		logic        op;
		pkt_fields_t f;
	} pkt_item_t;

	typedef struct packed {
		pqad_pkg::verdict_t verdict;
		res_fields_t        d;
	} verdict_item_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [pqad_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [pqad_pkg::CFG_W-1:0]     reg_val;
		pkt_item_t                      item;
		bit                             typed;
		verdict_item_t                  want;
	} stim_row_t;

	typedef struct {
		logic [31:0] limit;
		logic [1:0]  mode;
		logic [15:0] port;
		int          count;
		int          size_max;
		int          take_pct;
		int          sent_max;
	} test_phase_t;

	// DUT connections; every input starts at a known value
	logic         clk;
	logic         arst_n        = 1'b0;
	logic         cfg_wr_en     = 1'b0;
	logic [1:0]   cfg_index     = '0;
	logic [31:0]  cfg_wdata     = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata  = '0;   // is_ipv4, pkt_dir, ip_protocol, src_port, dst_port,
	                                    // filter_pass, packet_size, sent_bytes
	logic         s_axis_tuser  = 1'b0; // op
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;         // evicted_count, taken_size, queued_bytes,
	                                    // queued_packets, drop_count, zero pad
	logic [2:0]   m_axis_tuser;         // verdict

	// predicted queue state and register copies
	logic [19:0]  slot_size [DEPTH];
	int           rd_ptr;
	int           wr_ptr;
	int           fill;
	logic [31:0]  held_bytes;
	logic [31:0]  drop_rounds;
	logic [31:0]  budget;
	logic [1:0]   evict_mode;
	logic [15:0]  host_port;

	verdict_item_t pending_verdicts[$];
	stim_row_t     stim_rows[$];
	test_phase_t   phases[$];

	int  mismatches   = 0;
	int  sent_items   = 0;
	int  checked      = 0;
	int  cfg_writes   = 0;
	int  deepest_evict = 0;
	int  verdict_seen [8];
	int  tx_left      = 0;
	bit  tx_on        = 1'b0;

	packet_queue_admission_dropper u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drop everything queued: indices, count and byte total; the drop counter stays.
	function automatic void empty_queue();
		rd_ptr = 0;
		wr_ptr = 0;
		fill = 0;
		held_bytes = '0;
	endfunction

	// Compute the result item for one accepted input item and advance the predicted queue.
	function automatic verdict_item_t next_queue_result(input pkt_item_t it);
		verdict_item_t r;
		logic [19:0]   victim;
		bit            settled;
		bit            own;
		int            evicts;
		r = '0;
		evicts = 0;
		settled = 1'b0;
		own = it.f.is_ipv4 && (it.f.ip_protocol == pqad_pkg::PROTO_TCP
			|| it.f.ip_protocol == pqad_pkg::PROTO_UDP)
			&& ((it.f.pkt_dir == pqad_pkg::DIR_TO_HOST && it.f.dst_port == host_port)
			|| (it.f.pkt_dir == pqad_pkg::DIR_OUTGOING && it.f.src_port == host_port));
		if (it.op == pqad_pkg::OP_TAKE) begin
			if (fill == 0) begin
				r.verdict = pqad_pkg::V_EMPTY;
			end else begin
				r.d.taken_size = slot_size[rd_ptr];
				rd_ptr = (rd_ptr + 1) % DEPTH;
				fill--;
				// saturate at zero if the total ever runs short
				held_bytes = (held_bytes >= {12'd0, r.d.taken_size}) ?
					held_bytes - r.d.taken_size : '0;
				r.verdict = pqad_pkg::V_TAKEN;
			end
		end else if (own) begin
			r.verdict = pqad_pkg::V_OWN;
		end else if (!it.f.filter_pass) begin
			r.verdict = pqad_pkg::V_FILTERED;
		end else begin
			r.verdict = pqad_pkg::V_QUEUED;
			// budget sum is taken at 34 bits so it never wraps
			while (!settled && ({2'b00, held_bytes} + {2'b00, it.f.sent_bytes}
					+ {14'd0, it.f.packet_size} >= {2'b00, budget})) begin
				drop_rounds = drop_rounds + 32'd1;
				if (held_bytes < {12'd0, it.f.packet_size}
						|| evict_mode == pqad_pkg::DM_REFUSE) begin
					r.verdict = pqad_pkg::V_NOSPACE;
					settled = 1'b1;
				end else if (fill == 0) begin
					empty_queue();
					r.verdict = pqad_pkg::V_PURGE;
					settled = 1'b1;
				end else begin
					if (evict_mode == pqad_pkg::DM_HEAD) begin
						victim = slot_size[rd_ptr];
						rd_ptr = (rd_ptr + 1) % DEPTH;
					end else begin
						// tail drop, also for the unused mode code
						wr_ptr = (wr_ptr + DEPTH - 1) % DEPTH;
						victim = slot_size[wr_ptr];
					end
					fill--;
					if (held_bytes < {12'd0, victim}) begin
						empty_queue();
						r.verdict = pqad_pkg::V_PURGE;
						settled = 1'b1;
					end else begin
						held_bytes = held_bytes - victim;
						if (evicts < int'(pqad_pkg::EV_MAX))
							evicts++;
					end
				end
			end
			if (!settled) begin
				if (fill >= DEPTH) begin
					r.verdict = pqad_pkg::V_NOSPACE;
				end else begin
					slot_size[wr_ptr] = it.f.packet_size;
					wr_ptr = (wr_ptr + 1) % DEPTH;
					fill++;
					held_bytes = held_bytes + it.f.packet_size;
				end
			end
			r.d.evicted_count = 9'(evicts);
		end
		r.d.queued_bytes = held_bytes;
		r.d.queued_packets = 9'(fill);
		r.d.drop_count = drop_rounds;
		return r;
	endfunction

	// Idle length for one item: stretches with idling and stretches without follow in random order.
	function automatic int draw_gap(inout int left, inout bit on);
		if (left == 0) begin
			left = $urandom_range(8, 60);
			on = ($urandom_range(0, 2) != 0);
		end
		left--;
		return on ? int'($urandom_range(0, 4)) : 0;
	endfunction

	function automatic pkt_item_t arrival(input logic ipv4, input logic [1:0] dir,
			input logic [7:0] proto, input logic [15:0] sp, input logic [15:0] dp,
			input logic fp, input logic [19:0] size, input logic [31:0] sent);
		pkt_item_t it;
		it.op = pqad_pkg::OP_ARRIVE;
		it.f.is_ipv4 = ipv4;
		it.f.pkt_dir = dir;
		it.f.ip_protocol = proto;
		it.f.src_port = sp;
		it.f.dst_port = dp;
		it.f.filter_pass = fp;
		it.f.packet_size = size;
		it.f.sent_bytes = sent;
		return it;
	endfunction

	function automatic pkt_item_t take_head();
		pkt_item_t it;
		it = '0;
		it.op = pqad_pkg::OP_TAKE;
		return it;
	endfunction

	function automatic verdict_item_t outcome(input pqad_pkg::verdict_t v, input int ev,
			input int tk, input logic [31:0] qb, input int qp, input logic [31:0] dc);
		verdict_item_t r;
		r = '0;
		r.verdict = v;
		r.d.evicted_count = 9'(ev);
		r.d.taken_size = 20'(tk);
		r.d.queued_bytes = qb;
		r.d.queued_packets = 9'(qp);
		r.d.drop_count = dc;
		return r;
	endfunction

	function automatic void add_cfg(input logic [pqad_pkg::CFG_IDX_W-1:0] idx,
			input logic [pqad_pkg::CFG_W-1:0] val);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		r.item = '0;
		r.typed = 1'b0;
		r.want = '0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_item(input pkt_item_t it, input bit typed,
			input verdict_item_t want);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.item = it;
		r.typed = typed;
		r.want = want;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_phase(input logic [31:0] limit, input logic [1:0] mode,
			input logic [15:0] port, input int count, input int size_max, input int take_pct,
			input int sent_max);
		test_phase_t ph;
		ph.limit = limit;
		ph.mode = mode;
		ph.port = port;
		ph.count = count;
		ph.size_max = size_max;
		ph.take_pct = take_pct;
		ph.sent_max = sent_max;
		phases.push_back(ph);
	endfunction

	// Takes of the head at the phase's take percent, else mostly well-formed arrivals that reach
	// admission; some own traffic, filtered items, oversized packets and huge sent totals mixed in.
	function automatic pkt_item_t random_item(input test_phase_t ph);
		pkt_item_t it;
		int        pick;
		it.op = ($urandom_range(0, 99) < ph.take_pct) ? pqad_pkg::OP_TAKE : pqad_pkg::OP_ARRIVE;
		it.f.is_ipv4 = ($urandom_range(0, 9) != 0);
		it.f.pkt_dir = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 9);
		it.f.ip_protocol = (pick < 4) ? pqad_pkg::PROTO_TCP :
			(pick < 8) ? pqad_pkg::PROTO_UDP : 8'($urandom);
		it.f.src_port = 16'($urandom);
		it.f.dst_port = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			it.f.dst_port = host_port;
		else if (pick == 1)
			it.f.src_port = host_port;
		it.f.filter_pass = ($urandom_range(0, 9) != 0);
		it.f.packet_size = ($urandom_range(0, 31) == 0) ? 20'($urandom) :
			20'($urandom_range(0, ph.size_max));
		it.f.sent_bytes = ($urandom_range(0, 39) == 0) ? 32'($urandom) :
			32'($urandom_range(0, ph.sent_max));
		return it;
	endfunction

	// Write one register while the block is idle and mirror it in the predictor.
	task automatic write_reg(input logic [pqad_pkg::CFG_IDX_W-1:0] idx,
			input logic [pqad_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			pqad_pkg::REG_MEM_LIMIT: budget = val;
			pqad_pkg::REG_DROP_MODE: evict_mode = val[1:0];
			pqad_pkg::REG_OWN_PORT:  host_port = val[15:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Stop offering items and hold until every expected result item has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Offer one item after a random gap, hold it until accepted, then record its result.
	task automatic send_item(input pkt_item_t it, input bit typed, input verdict_item_t want);
		int            gap;
		verdict_item_t predicted;
		gap = draw_gap(tx_left, tx_on);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= it.f;
		do @(posedge clk); while (!s_axis_tready);
		predicted = next_queue_result(it);
		pending_verdicts.push_back(typed ? want : predicted);
		sent_items++;
	endtask

	// Stimulus: reset, directed table, random phases, drain and verdict.
	initial begin : stimulus
		int k;
		budget = pqad_pkg::MEM_LIMIT_RST;
		evict_mode = pqad_pkg::DM_REFUSE;
		host_port = '0;
		drop_rounds = '0;
		empty_queue();
		foreach (verdict_seen[v])
			verdict_seen[v] = 0;

		// Directed part. Expectations are typed in while the state is easy to follow
		// from reset; later rows go through the predictor.
		add_item(take_head(), 1'b1, outcome(pqad_pkg::V_EMPTY, 0, 0, 0, 0, 0));
		add_item(arrival(1'b1, pqad_pkg::DIR_TO_HOST, pqad_pkg::PROTO_TCP, 16'd1234, 16'd0,
			1'b1, 20'd100, 0), 1'b1, outcome(pqad_pkg::V_OWN, 0, 0, 0, 0, 0));
		// own traffic wins over a failing filter
		add_item(arrival(1'b1, pqad_pkg::DIR_OUTGOING, pqad_pkg::PROTO_UDP, 16'd0, 16'hFFFF,
			1'b0, 20'd100, 0), 1'b1, outcome(pqad_pkg::V_OWN, 0, 0, 0, 0, 0));
		// other directions are never own traffic
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_TCP, 16'd0, 16'd0, 1'b0, 20'd100, 0),
			1'b1, outcome(pqad_pkg::V_FILTERED, 0, 0, 0, 0, 0));
		add_item(arrival(1'b1, DIR_RESERVED, pqad_pkg::PROTO_UDP, 16'd0, 16'd0, 1'b0, 20'd100,
			0), 1'b1, outcome(pqad_pkg::V_FILTERED, 0, 0, 0, 0, 0));
		add_item(arrival(1'b0, pqad_pkg::DIR_TO_HOST, pqad_pkg::PROTO_TCP, 16'd0, 16'd0, 1'b1,
			20'd100, 0), 1'b1, outcome(pqad_pkg::V_QUEUED, 0, 0, 100, 1, 0));
		// largest packet crosses the default budget; refuse mode refuses it
		add_item(arrival(1'b1, pqad_pkg::DIR_TO_HOST, pqad_pkg::PROTO_TCP, 16'd0, 16'd1, 1'b1,
			20'hFFFFF, 0), 1'b1, outcome(pqad_pkg::V_NOSPACE, 0, 0, 100, 1, 1));
		add_item(arrival(1'b1, DIR_RESERVED, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 20'd0,
			32'hFFFF_FFFF), 1'b1, outcome(pqad_pkg::V_NOSPACE, 0, 0, 100, 1, 2));
		add_item(take_head(), 1'b1, outcome(pqad_pkg::V_TAKEN, 0, 100, 0, 0, 2));

		add_cfg(pqad_pkg::REG_OWN_PORT, 32'h0000_FFFF);
		add_item(arrival(1'b1, pqad_pkg::DIR_TO_HOST, pqad_pkg::PROTO_TCP, 16'd7, 16'hFFFF,
			1'b1, 20'd10, 0), 1'b0, '0);
		add_item(arrival(1'b1, pqad_pkg::DIR_OUTGOING, pqad_pkg::PROTO_UDP, 16'hFFFF, 16'd7,
			1'b1, 20'd10, 0), 1'b0, '0);
		add_item(arrival(1'b1, pqad_pkg::DIR_OUTGOING, pqad_pkg::PROTO_TCP, 16'd7, 16'hFFFF,
			1'b1, 20'd200, 0), 1'b0, '0);

		// head drop: the third packet forces two evictions
		add_cfg(pqad_pkg::REG_DROP_MODE, 32'(pqad_pkg::DM_HEAD));
		add_cfg(pqad_pkg::REG_MEM_LIMIT, 32'd1000);
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_TCP, 16'd1, 16'd2, 1'b1, 20'd300, 0),
			1'b0, '0);
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_TCP, 16'd1, 16'd2, 1'b1, 20'd300, 0),
			1'b0, '0);
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_TCP, 16'd1, 16'd2, 1'b1, 20'd400, 0),
			1'b0, '0);

		add_cfg(pqad_pkg::REG_DROP_MODE, 32'(pqad_pkg::DM_TAIL));
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_UDP, 16'd1, 16'd2, 1'b1, 20'd500,
			32'd200), 1'b0, '0);
		add_cfg(pqad_pkg::REG_DROP_MODE, 32'(DM_UNUSED));
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_UDP, 16'd1, 16'd2, 1'b1, 20'd600, 0),
			1'b0, '0);
		// not enough queued to free room for this one
		add_item(arrival(1'b1, DIR_OTHER, pqad_pkg::PROTO_UDP, 16'd1, 16'd2, 1'b1, 20'd999, 0),
			1'b0, '0);

		// zero budget: a zero-size packet evicts everything, then purges on the empty ring
		add_cfg(pqad_pkg::REG_MEM_LIMIT, 32'd0);
		add_cfg(pqad_pkg::REG_DROP_MODE, 32'(pqad_pkg::DM_HEAD));
		add_item(arrival(1'b0, DIR_OTHER, 8'd0, 16'd0, 16'd0, 1'b1, 20'd0, 0), 1'b0, '0);
		add_item(arrival(1'b0, DIR_OTHER, 8'd0, 16'd0, 16'd0, 1'b1, 20'd0, 0), 1'b0, '0);

		// full budget: the sum would wrap at 32 bits but must still exceed
		add_cfg(pqad_pkg::REG_MEM_LIMIT, 32'hFFFF_FFFF);
		add_item(arrival(1'b0, DIR_OTHER, 8'd0, 16'd0, 16'd0, 1'b1, 20'hFFFFF, 32'hFFFF_FFFF),
			1'b0, '0);
		add_item(take_head(), 1'b0, '0);
		add_item(arrival(1'b0, DIR_OTHER, 8'd0, 16'd0, 16'd0, 1'b1, 20'd5, 0), 1'b0, '0);
		add_item(take_head(), 1'b0, '0);

		// Random phases: limit, mode, own port, items, size max, take percent, sent max.
		// The second phase fills the ring; the third then evicts it with a zero budget.
		add_phase(32'd1048576, pqad_pkg::DM_REFUSE, 16'h0000, 150, 65535, 30, 500000);
		add_phase(32'hFFFF_FFFF, pqad_pkg::DM_TAIL, 16'hFFFF, 400, 4095, 3, 1000);
		add_phase(32'd0, pqad_pkg::DM_HEAD, 16'($urandom), 40, 200, 10, 100);
		add_phase(32'd20000, pqad_pkg::DM_HEAD, 16'($urandom), 200, 3000, 25, 8000);
		add_phase(32'd12000, pqad_pkg::DM_TAIL, 16'($urandom), 180, 2500, 25, 5000);
		add_phase(32'($urandom_range(1000, 1 << 20)), DM_UNUSED, 16'($urandom), 170, 50000, 30,
			200000);

		// hold reset asserted, then release it at a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_CFG) begin
				wait_drained();
				write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
			end else begin
				send_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want);
			end
		end

		foreach (phases[p]) begin
			wait_drained();
			write_reg(pqad_pkg::REG_MEM_LIMIT, phases[p].limit);
			write_reg(pqad_pkg::REG_DROP_MODE, pqad_pkg::CFG_W'(phases[p].mode));
			write_reg(pqad_pkg::REG_OWN_PORT, pqad_pkg::CFG_W'(phases[p].port));
			for (k = 0; k < phases[p].count; k++)
				send_item(random_item(phases[p]), 1'b0, '0);
		end

		// drain, then give a stray result item time to show up
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0)
			mismatches++;

		$display("Covered %0d items, %0d register writes; queued %0d, own %0d, filtered %0d",
			sent_items, cfg_writes, verdict_seen[pqad_pkg::V_QUEUED],
			verdict_seen[pqad_pkg::V_OWN], verdict_seen[pqad_pkg::V_FILTERED]);
		$display("no space %0d, purged %0d, taken %0d, empty takes %0d, deepest eviction %0d",
			verdict_seen[pqad_pkg::V_NOSPACE], verdict_seen[pqad_pkg::V_PURGE],
			verdict_seen[pqad_pkg::V_TAKEN], verdict_seen[pqad_pkg::V_EMPTY], deepest_evict);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Receiver: stall at random, hold off once for a long stretch so the block backs up,
	// and compare every result item against the oldest expectation.
	initial begin : result_sink
		verdict_item_t got;
		verdict_item_t want;
		int            gap;
		int            rx_left;
		bit            rx_on;
		rx_left = 0;
		rx_on = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (checked == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_left, rx_on);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			got.verdict = pqad_pkg::verdict_t'(m_axis_tuser);
			got.d = m_axis_tdata;
			checked++;
			if (m_axis_tuser <= 3'(pqad_pkg::V_EMPTY))
				verdict_seen[m_axis_tuser]++;
			if (int'(got.d.evicted_count) > deepest_evict)
				deepest_evict = got.d.evicted_count;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result item with nothing expected: v=%0d tdata=%h", $realtime,
						m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.verdict !== want.verdict
						|| got.d.evicted_count !== want.d.evicted_count
						|| got.d.taken_size !== want.d.taken_size
						|| got.d.queued_bytes !== want.d.queued_bytes
						|| got.d.queued_packets !== want.d.queued_packets
						|| got.d.drop_count !== want.d.drop_count) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("%0t: result %0d exp v=%0d ev=%0d tk=%0d qb=%0d qp=%0d dc=%0d",
							$realtime, checked, want.verdict, want.d.evicted_count,
							want.d.taken_size, want.d.queued_bytes, want.d.queued_packets,
							want.d.drop_count);
						$display("    got v=%0d ev=%0d tk=%0d qb=%0d qp=%0d dc=%0d",
							got.verdict, got.d.evicted_count, got.d.taken_size,
							got.d.queued_bytes, got.d.queued_packets, got.d.drop_count);
					end
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* packet_queue_admission_dropper.f */
+incdir+design
design/pqad_pkg.sv
design/packet_queue_admission_dropper.sv
sim/tb_packet_queue_admission_dropper.sv
